[sv/fdc_pkg.sv]
// Shared types and constants for the fall detector with tilt confirmation.
// Holds the register map, configuration record and mode encoding.
// No dependencies.
`default_nettype none

package fdc_pkg;

  localparam int unsigned TIME_BITS_DEF = 48;
  localparam int unsigned SAMPLE_TIME_W = 48;
  localparam int unsigned ACCEL_W       = 16;
  localparam int unsigned TILT_W        = 11;
  localparam int unsigned DELAY_W       = 32;
  localparam int unsigned APB_ADDR_W    = 5;
  localparam int unsigned APB_DATA_W    = 32;

  localparam logic [ACCEL_W-1:0] SPIKE_THRESHOLD_RST = 16'd640;
  localparam logic [TILT_W-1:0]  CONFIRM_TILT_RST    = 11'd600;
  localparam logic [DELAY_W-1:0] CONFIRM_DELAY_RST   = 32'd500000;
  localparam logic [DELAY_W-1:0] COOLDOWN_TIME_RST   = 32'd30000000;
  localparam logic [TILT_W-1:0]  CLEAR_TILT_RST      = 11'd300;
  localparam logic [DELAY_W-1:0] CLEAR_HOLD_RST      = 32'd10000000;

  typedef enum logic [2:0] {
    REG_SPIKE_THRESHOLD = 3'd0,
    REG_CONFIRM_TILT    = 3'd1,
    REG_CONFIRM_DELAY   = 3'd2,
    REG_COOLDOWN_TIME   = 3'd3,
    REG_CLEAR_TILT      = 3'd4,
    REG_CLEAR_HOLD      = 3'd5
  } fdc_reg_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SPIKE  = 2'd1,
    MODE_FALLEN = 2'd2
  } fdc_mode_e;

  typedef struct packed {
    logic [ACCEL_W-1:0] spike_threshold;
    logic [TILT_W-1:0]  confirm_tilt;
    logic [DELAY_W-1:0] confirm_delay;
    logic [DELAY_W-1:0] cooldown_time;
    logic [TILT_W-1:0]  clear_tilt;
    logic [DELAY_W-1:0] clear_hold;
  } fdc_cfg_t;

endpackage

`default_nettype wire

[sv/fdc_regs.sv]
// Configuration register file of the fall detector, behind an APB-style port.
// Depends on fdc_pkg for the register map and the configuration record.
`default_nettype none

module fdc_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel_i,
  input  wire logic                             penable_i,
  input  wire logic                             pwrite_i,
  input  wire logic [fdc_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  wire logic [fdc_pkg::APB_DATA_W-1:0]   pwdata_i,
  output logic      [fdc_pkg::APB_DATA_W-1:0]   prdata_o,
  output fdc_pkg::fdc_cfg_t                     cfg_o
);

  fdc_pkg::fdc_cfg_t cfg_q;
  logic [2:0]        sel;
  logic              wr_en;

  assign sel   = paddr_i[fdc_pkg::APB_ADDR_W-1:2];
  assign wr_en = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spike_threshold <= fdc_pkg::SPIKE_THRESHOLD_RST;
      cfg_q.confirm_tilt    <= fdc_pkg::CONFIRM_TILT_RST;
      cfg_q.confirm_delay   <= fdc_pkg::CONFIRM_DELAY_RST;
      cfg_q.cooldown_time   <= fdc_pkg::COOLDOWN_TIME_RST;
      cfg_q.clear_tilt      <= fdc_pkg::CLEAR_TILT_RST;
      cfg_q.clear_hold      <= fdc_pkg::CLEAR_HOLD_RST;
    end else if (wr_en) begin
      case (sel)
        fdc_pkg::REG_SPIKE_THRESHOLD: cfg_q.spike_threshold <= pwdata_i[fdc_pkg::ACCEL_W-1:0];
        fdc_pkg::REG_CONFIRM_TILT:    cfg_q.confirm_tilt    <= pwdata_i[fdc_pkg::TILT_W-1:0];
        fdc_pkg::REG_CONFIRM_DELAY:   cfg_q.confirm_delay   <= pwdata_i[fdc_pkg::DELAY_W-1:0];
        fdc_pkg::REG_COOLDOWN_TIME:   cfg_q.cooldown_time   <= pwdata_i[fdc_pkg::DELAY_W-1:0];
        fdc_pkg::REG_CLEAR_TILT:      cfg_q.clear_tilt      <= pwdata_i[fdc_pkg::TILT_W-1:0];
        fdc_pkg::REG_CLEAR_HOLD:      cfg_q.clear_hold      <= pwdata_i[fdc_pkg::DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (sel)
      fdc_pkg::REG_SPIKE_THRESHOLD: prdata_o = fdc_pkg::APB_DATA_W'(cfg_q.spike_threshold);
      fdc_pkg::REG_CONFIRM_TILT:    prdata_o = fdc_pkg::APB_DATA_W'(cfg_q.confirm_tilt);
      fdc_pkg::REG_CONFIRM_DELAY:   prdata_o = fdc_pkg::APB_DATA_W'(cfg_q.confirm_delay);
      fdc_pkg::REG_COOLDOWN_TIME:   prdata_o = fdc_pkg::APB_DATA_W'(cfg_q.cooldown_time);
      fdc_pkg::REG_CLEAR_TILT:      prdata_o = fdc_pkg::APB_DATA_W'(cfg_q.clear_tilt);
      fdc_pkg::REG_CLEAR_HOLD:      prdata_o = fdc_pkg::APB_DATA_W'(cfg_q.clear_hold);
      default:                      prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/fall_detector_with_confirm.sv]
// Top level of the fall detector with tilt confirmation: input register,
// mode state machine and result register. Depends on fdc_pkg and fdc_regs.
//
// Usage: one IMU sample (acceleration magnitude, tilt, microsecond timestamp)
// is offered per item on the input valid/ready channel, and exactly one result
// item (fall flag, raised and cleared pulses, mode after the sample) leaves on
// the output valid/ready channel for each input item, in order.
// An accepted item is held in the input register; once the result register is
// free or being taken, the state machine evaluates it and loads the result.
// The block takes one item every cycle while the receiver keeps up; the input
// register and the result register form two stages, and the compares of the
// timestamp against the stored spike, fall and upright times set the path.
// When the receiver stalls, the result register holds its item, the input
// register holds one more, and ready drops until the result is taken.
// Reset clears both stages, puts the machine in normal mode with all stored
// times at zero, and loads the configuration registers with their defaults.
// Configuration must be written via the APB-style port while no item is in
// flight (unchecked); writes land at the access cycle; pready is always high.
`default_nettype none

module fall_detector_with_confirm #(
  parameter int unsigned TIME_BITS = fdc_pkg::TIME_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [fdc_pkg::ACCEL_W-1:0]         accel_magnitude_i,
  input  wire logic [fdc_pkg::TILT_W-1:0]          tilt_i,
  input  wire logic [fdc_pkg::SAMPLE_TIME_W-1:0]   sample_time_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     fall_flag_o,
  output logic                                     fall_raised_o,
  output logic                                     fall_cleared_o,
  output logic [1:0]                               machine_state_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [fdc_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [fdc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [fdc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                     pready
);

  // Timestamps never carry more bits than the sample field.
  localparam int unsigned TW = (TIME_BITS < fdc_pkg::SAMPLE_TIME_W) ?
                               TIME_BITS : fdc_pkg::SAMPLE_TIME_W;

  fdc_pkg::fdc_cfg_t cfg;

  fdc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  logic                        in_valid_q;
  logic [fdc_pkg::ACCEL_W-1:0] accel_q;
  logic [fdc_pkg::TILT_W-1:0]  tilt_q;
  logic [TW-1:0]               now_q;

  logic out_valid_q, flag_q, raised_q, cleared_q;
  fdc_pkg::fdc_mode_e out_mode_q;

  fdc_pkg::fdc_mode_e mode_q, mode_d;
  logic [TW-1:0] spike_time_q, spike_time_d;
  logic [TW-1:0] upright_q, upright_d;
  logic [TW-1:0] last_fall_q, last_fall_d;
  logic flag, raised, cleared;

  logic advance, in_fire;
  logic [TW:0] spike_diff, fall_diff, upright_diff;
  logic delay_met, cooldown_met, hold_met;

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_fire    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      accel_q <= accel_magnitude_i;
      tilt_q  <= tilt_i;
      now_q   <= sample_time_i[TW-1:0];
    end
  end

  // The top bit of each difference is the borrow: a set borrow means the
  // timestamp went backwards, which never meets a delay.
  assign spike_diff   = {1'b0, now_q} - {1'b0, spike_time_q};
  assign fall_diff    = {1'b0, now_q} - {1'b0, last_fall_q};
  assign upright_diff = {1'b0, now_q} - {1'b0, upright_q};

  assign delay_met    = ~spike_diff[TW] & (spike_diff[TW-1:0] >= TW'(cfg.confirm_delay));
  assign cooldown_met = ~fall_diff[TW] & (fall_diff[TW-1:0] > TW'(cfg.cooldown_time));
  assign hold_met     = ~upright_diff[TW] & (upright_diff[TW-1:0] >= TW'(cfg.clear_hold));

  always_comb begin
    mode_d       = mode_q;
    spike_time_d = spike_time_q;
    upright_d    = upright_q;
    last_fall_d  = last_fall_q;
    flag         = (mode_q == fdc_pkg::MODE_FALLEN);
    raised       = 1'b0;
    cleared      = 1'b0;
    case (mode_q)
      fdc_pkg::MODE_NORMAL: begin
        if (accel_q > cfg.spike_threshold) begin
          mode_d       = fdc_pkg::MODE_SPIKE;
          spike_time_d = now_q;
        end
        upright_d = now_q;
      end
      fdc_pkg::MODE_SPIKE: begin
        if (delay_met) begin
          if ((tilt_q > cfg.confirm_tilt) && cooldown_met) begin
            mode_d      = fdc_pkg::MODE_FALLEN;
            last_fall_d = now_q;
            raised      = 1'b1;
            flag        = 1'b1;
          end else begin
            mode_d = fdc_pkg::MODE_NORMAL;
          end
        end
      end
      fdc_pkg::MODE_FALLEN: begin
        if (tilt_q < cfg.clear_tilt) begin
          if (hold_met) begin
            mode_d  = fdc_pkg::MODE_NORMAL;
            cleared = 1'b1;
          end
        end else begin
          upright_d = now_q;
        end
      end
      default: begin
        mode_d = fdc_pkg::MODE_NORMAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= fdc_pkg::MODE_NORMAL;
      spike_time_q <= '0;
      upright_q    <= '0;
      last_fall_q  <= '0;
    end else if (advance) begin
      mode_q       <= mode_d;
      spike_time_q <= spike_time_d;
      upright_q    <= upright_d;
      last_fall_q  <= last_fall_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      flag_q     <= flag;
      raised_q   <= raised;
      cleared_q  <= cleared;
      out_mode_q <= mode_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fall_flag_o     = flag_q;
  assign fall_raised_o   = raised_q;
  assign fall_cleared_o  = cleared_q;
  assign machine_state_o = out_mode_q;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for fall_detector_with_confirm: random and directed IMU
// samples, APB register writes with readback, and a per-sample predictor of the
// normal/spike/fallen state machine. Depends on fdc_pkg and the block's RTL.
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [fdc_pkg::ACCEL_W-1:0]       accel;
    logic [fdc_pkg::TILT_W-1:0]        tilt;
    logic [fdc_pkg::SAMPLE_TIME_W-1:0] stamp;
  } imu_sample_t;

  typedef struct packed {
    logic               flag;
    logic               raised;
    logic               cleared;
    fdc_pkg::fdc_mode_e mode;
  } fall_report_t;

  typedef enum int {CFG_KEEP, CFG_ZERO, CFG_MAX, CFG_SHORT, CFG_WIDE, CFG_DIRTY} cfg_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [fdc_pkg::ACCEL_W-1:0] accel_drv = '0;
  logic [fdc_pkg::TILT_W-1:0] tilt_drv = '0;
  logic [fdc_pkg::SAMPLE_TIME_W-1:0] time_drv = '0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fdc_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [fdc_pkg::APB_DATA_W-1:0] pwdata = '0;

  logic in_ready;
  logic out_valid;
  logic fall_flag;
  logic fall_raised;
  logic fall_cleared;
  logic [1:0] machine_state;
  logic [fdc_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  fall_detector_with_confirm dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .accel_magnitude_i (accel_drv),
    .tilt_i            (tilt_drv),
    .sample_time_i     (time_drv),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .fall_flag_o       (fall_flag),
    .fall_raised_o     (fall_raised),
    .fall_cleared_o    (fall_cleared),
    .machine_state_o   (machine_state),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  imu_sample_t pending_samples[$];
  fall_report_t expected_reports[$];
  imu_sample_t staged;
  fall_report_t awaited;

  fdc_pkg::fdc_cfg_t cfg_m;
  fdc_pkg::fdc_mode_e mode_m;
  logic [fdc_pkg::SAMPLE_TIME_W-1:0] spike_at;
  logic [fdc_pkg::SAMPLE_TIME_W-1:0] upright_at;
  logic [fdc_pkg::SAMPLE_TIME_W-1:0] last_fall_at;

  int mismatches = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 63;
  int hold_request = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [63:0] stim_clock;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [49:0] span(logic [fdc_pkg::SAMPLE_TIME_W-1:0] now,
                                              logic [fdc_pkg::SAMPLE_TIME_W-1:0] then_t);
    return $signed({2'b00, now}) - $signed({2'b00, then_t});
  endfunction

  function automatic fall_report_t predict_fall_step(imu_sample_t s);
    fall_report_t r;
    r.flag = (mode_m == fdc_pkg::MODE_FALLEN);
    r.raised = 1'b0;
    r.cleared = 1'b0;
    case (mode_m)
      fdc_pkg::MODE_NORMAL: begin
        if (s.accel > cfg_m.spike_threshold) begin
          mode_m = fdc_pkg::MODE_SPIKE;
          spike_at = s.stamp;
        end
        upright_at = s.stamp;
      end
      fdc_pkg::MODE_SPIKE: begin
        if (span(s.stamp, spike_at) >= $signed({18'd0, cfg_m.confirm_delay})) begin
          if (s.tilt > cfg_m.confirm_tilt &&
              span(s.stamp, last_fall_at) > $signed({18'd0, cfg_m.cooldown_time})) begin
            mode_m = fdc_pkg::MODE_FALLEN;
            last_fall_at = s.stamp;
            r.raised = 1'b1;
            r.flag = 1'b1;
          end else begin
            mode_m = fdc_pkg::MODE_NORMAL;
          end
        end
      end
      fdc_pkg::MODE_FALLEN: begin
        if (s.tilt < cfg_m.clear_tilt) begin
          if (span(s.stamp, upright_at) >= $signed({18'd0, cfg_m.clear_hold})) begin
            mode_m = fdc_pkg::MODE_NORMAL;
            r.cleared = 1'b1;
          end
        end else begin
          upright_at = s.stamp;
        end
      end
      default: mode_m = fdc_pkg::MODE_NORMAL;
    endcase
    r.mode = mode_m;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      expected_reports.push_back(predict_fall_step(staged));
    end
    if (!in_valid || in_ready) begin
      if (rst_ni && pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        staged = pending_samples.pop_front();
        accel_drv <= staged.accel;
        tilt_drv <= staged.tilt;
        time_drv <= staged.stamp;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string field, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result item with nothing expected: flag %0b raised %0b cleared %0b state %0d",
                 $time, fall_flag, fall_raised, fall_cleared, machine_state);
        mismatches++;
      end else begin
        awaited = expected_reports.pop_front();
        check_field("fall_flag", awaited.flag, fall_flag);
        check_field("fall_raised", awaited.raised, fall_raised);
        check_field("fall_cleared", awaited.cleared, fall_cleared);
        check_field("machine_state", awaited.mode, machine_state);
      end
    end
    if (hold_served != hold_request) begin
      hold_served = hold_request;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] reg_mask(fdc_pkg::fdc_reg_e idx);
    case (idx)
      fdc_pkg::REG_SPIKE_THRESHOLD: return 32'h0000_FFFF;
      fdc_pkg::REG_CONFIRM_TILT, fdc_pkg::REG_CLEAR_TILT: return 32'h0000_07FF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic write_register(fdc_pkg::fdc_reg_e idx, logic [31:0] value);
    logic [31:0] kept;
    kept = value & reg_mask(idx);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      fdc_pkg::REG_SPIKE_THRESHOLD: cfg_m.spike_threshold = kept[fdc_pkg::ACCEL_W-1:0];
      fdc_pkg::REG_CONFIRM_TILT:    cfg_m.confirm_tilt = kept[fdc_pkg::TILT_W-1:0];
      fdc_pkg::REG_CONFIRM_DELAY:   cfg_m.confirm_delay = kept;
      fdc_pkg::REG_COOLDOWN_TIME:   cfg_m.cooldown_time = kept;
      fdc_pkg::REG_CLEAR_TILT:      cfg_m.clear_tilt = kept[fdc_pkg::TILT_W-1:0];
      default:                      cfg_m.clear_hold = kept;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept) begin
      $display("%0t: readback of register %s: expected %0h, actual %0h",
               $time, idx.name(), kept, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_settings(cfg_kind_e kind);
    logic [31:0] v [6];
    case (kind)
      CFG_KEEP: return;
      CFG_ZERO: v = '{default: 32'd0};
      CFG_MAX: v = '{32'hFFFF, 32'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FF, 32'hFFFF_FFFF};
      CFG_WIDE: v = '{$urandom_range(0, 65535), $urandom_range(0, 1800), $urandom(),
                      $urandom(), $urandom_range(0, 1800), $urandom()};
      default: v = '{$urandom_range(0, 65535), $urandom_range(0, 1800), $urandom_range(0, 3000),
                     $urandom_range(0, 8000), $urandom_range(0, 1800), $urandom_range(0, 5000)};
    endcase
    for (int i = 0; i < 6; i++) begin
      if (kind == CFG_DIRTY) begin
        v[i] = v[i] | ($urandom() & ~reg_mask(fdc_pkg::fdc_reg_e'(i)));
      end
      write_register(fdc_pkg::fdc_reg_e'(i), v[i]);
    end
  endtask

  task automatic offer_sample(logic [fdc_pkg::ACCEL_W-1:0] accel,
                              logic [fdc_pkg::TILT_W-1:0] tilt,
                              logic [fdc_pkg::SAMPLE_TIME_W-1:0] stamp);
    pending_samples.push_back('{accel, tilt, stamp});
  endtask

  function automatic logic [63:0] near(logic [63:0] base);
    case ($urandom_range(0, 3))
      0: return (base == 0) ? base : base - 1;
      1: return base;
      2: return base + 1;
      default: return base + $urandom_range(0, 100000);
    endcase
  endfunction

  function automatic logic [63:0] pick_gap();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 100000);
      2: return near(cfg_m.cooldown_time);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [fdc_pkg::TILT_W-1:0] tilt_above(int unsigned limit);
    return (limit < 1800) ? fdc_pkg::TILT_W'($urandom_range(limit + 1, 1800)) : 11'h7FF;
  endfunction

  task automatic queue_directed();
    offer_sample(16'd0, 11'd0, 48'd0);
    offer_sample(16'hFFFF, 11'd0, 48'd1000);
    offer_sample(16'd0, 11'h7FF, 48'd600000);
    offer_sample(16'd640, 11'd0, 48'd40000000);
    offer_sample(16'd641, 11'd1800, 48'd40100000);
    offer_sample(16'd0, 11'd1800, 48'd40599999);
    offer_sample(16'd0, 11'd600, 48'd40600000);
    offer_sample(16'd1000, 11'd0, 48'd41000000);
    offer_sample(16'd0, 11'd601, 48'd41500000);
    offer_sample(16'd0, 11'd300, 48'd42000000);
    offer_sample(16'd0, 11'h7FF, 48'd43000000);
    offer_sample(16'd0, 11'd0, 48'd52999999);
    offer_sample(16'd0, 11'd299, 48'd53000000);
    offer_sample(16'hFFFF, 11'd0, 48'd60000000);
    offer_sample(16'd0, 11'd1800, 48'd60500000);
    offer_sample(16'hFFFF, 11'd0, 48'd71000000);
    offer_sample(16'd0, 11'd1800, 48'd71500000);
    offer_sample(16'hFFFF, 11'd0, 48'd72000000);
    offer_sample(16'd0, 11'd1800, 48'd72500001);
    offer_sample(16'd0, 11'd0, 48'd50000000);
    offer_sample(16'd0, 11'd0, 48'hFFFF_FFFF_FFFF);
    offer_sample(16'hFFFF, 11'd0, 48'd100000);
    offer_sample(16'd0, 11'd1800, 48'd50000);
    offer_sample(16'd0, 11'd1800, 48'd600000);
    offer_sample(16'd0, 11'd0, 48'd80000000);
  endtask

  task automatic queue_random(int count);
    logic [63:0] t_spike;
    logic [63:0] t_up;
    logic [63:0] at;
    logic [fdc_pkg::TILT_W-1:0] tilt;
    int unsigned thr;
    while (pending_samples.size() < count) begin
      if ($urandom_range(0, 99) < 15) begin
        at = $urandom_range(0, 1) ? stim_clock - $urandom_range(0, 5000) : stim_clock + $urandom();
        offer_sample(fdc_pkg::ACCEL_W'($urandom()), fdc_pkg::TILT_W'($urandom_range(0, 2047)),
                     at[47:0]);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          stim_clock += $urandom_range(0, 100000);
          offer_sample(fdc_pkg::ACCEL_W'($urandom_range(0, cfg_m.spike_threshold)),
                       fdc_pkg::TILT_W'($urandom_range(0, 1800)), stim_clock[47:0]);
        end
        stim_clock += $urandom_range(0, 50);
        thr = cfg_m.spike_threshold;
        offer_sample(fdc_pkg::ACCEL_W'((thr == 65535) ? 65535 : $urandom_range(thr + 1, 65535)),
                     fdc_pkg::TILT_W'($urandom_range(0, 1800)), stim_clock[47:0]);
        t_spike = stim_clock;
        t_up = stim_clock;
        repeat ($urandom_range(0, 2)) begin
          stim_clock += $urandom_range(0, cfg_m.confirm_delay / 3);
          offer_sample(fdc_pkg::ACCEL_W'($urandom()), fdc_pkg::TILT_W'($urandom_range(0, 1800)),
                       stim_clock[47:0]);
        end
        at = near(t_spike + cfg_m.confirm_delay);
        stim_clock = (at < stim_clock) ? stim_clock : at;
        tilt = ($urandom_range(0, 3) != 0) ? tilt_above(cfg_m.confirm_tilt)
                                           : fdc_pkg::TILT_W'($urandom_range(0, cfg_m.confirm_tilt));
        offer_sample(fdc_pkg::ACCEL_W'($urandom()), tilt, stim_clock[47:0]);
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 9) < 7) begin
            at = near(t_up + cfg_m.clear_hold);
            at = (at < stim_clock) ? stim_clock : at;
            tilt = (cfg_m.clear_tilt == 0) ? 11'd0
                                           : fdc_pkg::TILT_W'($urandom_range(0, cfg_m.clear_tilt - 1));
          end else begin
            at = stim_clock + $urandom_range(0, 1000);
            tilt = fdc_pkg::TILT_W'($urandom_range(cfg_m.clear_tilt,
                                                   (cfg_m.clear_tilt > 1800) ? 2047 : 1800));
            t_up = at;
          end
          stim_clock = at;
          offer_sample(fdc_pkg::ACCEL_W'($urandom()), tilt, stim_clock[47:0]);
        end
        stim_clock += pick_gap();
      end
    end
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_reports.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    cfg_kind_e plan_kind [7];
    int plan_count [7];
    plan_kind = '{CFG_KEEP, CFG_ZERO, CFG_MAX, CFG_SHORT, CFG_WIDE, CFG_DIRTY, CFG_SHORT};
    plan_count = '{350, 250, 100, 300, 350, 300, 350};
    cfg_m = '{spike_threshold: fdc_pkg::SPIKE_THRESHOLD_RST,
              confirm_tilt: fdc_pkg::CONFIRM_TILT_RST,
              confirm_delay: fdc_pkg::CONFIRM_DELAY_RST,
              cooldown_time: fdc_pkg::COOLDOWN_TIME_RST,
              clear_tilt: fdc_pkg::CLEAR_TILT_RST,
              clear_hold: fdc_pkg::CLEAR_HOLD_RST};
    mode_m = fdc_pkg::MODE_NORMAL;
    spike_at = '0;
    upright_at = '0;
    last_fall_at = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    drain();
    stim_clock = 64'd100000000;
    for (int p = 0; p < 7; p++) begin
      load_settings(plan_kind[p]);
      case (p % 3)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == 5) begin
        stim_clock = {16'd0, 3'b011, 13'($urandom()), 32'($urandom())};
      end else if (p == 6) begin
        stim_clock = {16'd0, 3'b101, 13'($urandom()), 32'($urandom())};
      end else begin
        stim_clock += $urandom_range(0, 1000000);
      end
      queue_random(plan_count[p]);
      if (p % 3 == 2) begin
        hold_request++;
      end
      drain();
    end
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
